### design/smf_pkg.sv
// Shared types and constants of the substring mask filter.
package smf_pkg;

    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 5;
    localparam int MASK_W         = 4;
    localparam int PAT_BYTES      = 16;
    localparam int PAT_W          = PAT_BYTES * BYTE_W;
    localparam int LEN_HW_LIMIT   = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;

    localparam logic [BYTE_W-1:0] ASTERISK  = 8'd42;
    localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'd0;
    localparam logic [LEN_W-1:0]  LEN_RESET = 5'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 2'd2;

    typedef struct packed {
        logic step;   // accept the input transaction and run one window step
        logic pop;    // emit and drop the oldest window byte during flush
    } smf_cmd_t;

    typedef struct packed {
        logic out_free;      // result register can load this cycle
        logic remain_after;  // window still holds bytes after this step
        logic last_pop;      // exactly one byte left in the window
    } smf_status_t;

endpackage

### design/smf_byte_if.sv
// Input byte channel: valid/ready handshake with data byte and end marker.
interface smf_byte_if
    import smf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

### design/smf_result_if.sv
// Result byte channel: valid/ready handshake with filtered byte and last flag.
interface smf_result_if
    import smf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### design/smf_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
interface smf_cfg_if
    import smf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

### design/smf_ctrl.sv
// Controller state machine: input acceptance and window flush sequencing.
module smf_ctrl
    import smf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_end,
    input  smf_status_t status,
    output logic        in_ready,
    output smf_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE) && status.out_free;
        cmd.step   = in_valid && in_ready;
        cmd.pop    = (state_reg == ST_FLUSH) && status.out_free;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.step && in_end && status.remain_after)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (cmd.pop && status.last_pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/smf_datapath.sv
// Datapath: pattern registers, byte window, match compare, mask count, result register.
module smf_datapath
    import smf_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  smf_cmd_t          cmd,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_end,
    output smf_status_t       status,
    smf_result_if.source      result,
    smf_cfg_if.sink           cfg
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int LIMIT = (MAX_PATTERN < LEN_HW_LIMIT) ? MAX_PATTERN : LEN_HW_LIMIT;
    localparam logic [LEN_W-1:0] LIMIT_LEN = LEN_W'(LIMIT);

    logic [LEN_W-1:0]  len_cfg_reg;
    logic [LEN_W-1:0]  len_cfg_next;
    logic [PAT_W-1:0]  pat_reg;
    logic [PAT_W-1:0]  pat_next;
    logic [BYTE_W-1:0] win_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN];
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic              term_reg;
    logic              term_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic [LEN_W-1:0]  len5;
    logic [CNT_W-1:0]  active_len;
    logic [BYTE_W-1:0] cand    [MAX_PATTERN];
    logic [BYTE_W-1:0] cand_sh [MAX_PATTERN];
    logic [BYTE_W-1:0] win_sh  [MAX_PATTERN];
    logic [BYTE_W-1:0] pat_byte;
    logic              match;
    logic              full;
    logic              live;
    logic [CNT_W-1:0]  fill_after;
    logic              emit;
    logic              step_emit;

    assign cfg.ready     = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.out_last = out_last_reg;

    // Clamp the programmed length to the supported range.
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len5 = LEN_W'(1);
        end
        else if (len_cfg_reg > LIMIT_LEN)
        begin
            len5 = LIMIT_LEN;
        end
        else
        begin
            len5 = len_cfg_reg;
        end
        active_len = CNT_W'(len5);
    end

    // Window with the new byte inserted, and its parallel compare.
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            cand[i] = (fill_reg == CNT_W'(i)) ? in_byte : win_reg[i];
            pat_byte = (i < PAT_BYTES) ? pat_reg[BYTE_W*(i % PAT_BYTES) +: BYTE_W] : NUL_BYTE;
            if ((CNT_W'(i) < active_len) && (cand[i] != pat_byte))
            begin
                match = 1'b0;
            end
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            cand_sh[i] = (i + 1 < MAX_PATTERN) ? cand[(i + 1) % MAX_PATTERN] : NUL_BYTE;
            win_sh[i]  = (i + 1 < MAX_PATTERN) ? win_reg[(i + 1) % MAX_PATTERN] : NUL_BYTE;
        end
    end

    assign live       = !term_reg && (in_byte != NUL_BYTE);
    assign full       = (CNT_W'(fill_reg + CNT_W'(1)) == active_len);
    assign step_emit  = live && full;
    assign fill_after = (live && !full) ? CNT_W'(fill_reg + CNT_W'(1)) : fill_reg;
    assign emit       = (cmd.step && step_emit) || cmd.pop;

    assign status.out_free     = !out_valid_reg || result.ready;
    assign status.remain_after = (fill_after != '0);
    assign status.last_pop     = (fill_reg == CNT_W'(1));

    always_comb
    begin
        len_cfg_next   = len_cfg_reg;
        pat_next       = pat_reg;
        win_next       = win_reg;
        fill_next      = fill_reg;
        mask_next      = mask_reg;
        term_next      = term_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = emit || (out_valid_reg && !result.ready);

        if (cmd.step)
        begin
            if (live)
            begin
                if (full)
                begin
                    win_next = cand_sh;
                end
                else
                begin
                    win_next = cand;
                end
                fill_next = fill_after;
                if (full)
                begin
                    if (mask_reg != '0)
                    begin
                        mask_next = mask_reg - MASK_W'(1);
                    end
                    else if (match)
                    begin
                        mask_next = MASK_W'(active_len - CNT_W'(1));
                    end
                    out_byte_next = ((mask_reg != '0) || match) ? ASTERISK : cand[0];
                    out_last_next = in_end && (fill_after == '0);
                end
            end
            else if (!term_reg)
            begin
                term_next = 1'b1;
            end
            // End of stream: reopen the stream, keep the window for the flush.
            if (in_end)
            begin
                term_next = 1'b0;
                if (fill_after == '0)
                begin
                    mask_next = '0;
                end
            end
        end

        if (cmd.pop)
        begin
            win_next      = win_sh;
            fill_next     = fill_reg - CNT_W'(1);
            out_byte_next = (mask_reg != '0) ? ASTERISK : win_reg[0];
            out_last_next = status.last_pop;
            if (mask_reg != '0)
            begin
                mask_next = mask_reg - MASK_W'(1);
            end
            if (status.last_pop)
            begin
                mask_next = '0;
                term_next = 1'b0;
            end
        end

        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                CFG_LENGTH:
                begin
                    len_cfg_next = cfg.write_data[LEN_W-1:0];
                    fill_next    = '0;
                    mask_next    = '0;
                    term_next    = 1'b0;
                end
                CFG_LOW:
                begin
                    pat_next[CFG_DATA_W-1:0] = cfg.write_data;
                end
                CFG_HIGH:
                begin
                    pat_next[PAT_W-1:CFG_DATA_W] = cfg.write_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= LEN_RESET;
            pat_reg       <= '0;
            fill_reg      <= '0;
            mask_reg      <= '0;
            term_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_cfg_reg   <= len_cfg_next;
            pat_reg       <= pat_next;
            fill_reg      <= fill_next;
            mask_reg      <= mask_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg      <= win_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // The window never reaches the full length between steps.
    a_fill_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < active_len)
        else $error("window fill reached the pattern length");

    // Bytes still to be masked are always bytes that sit in the window.
    a_mask_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        int'(mask_reg) <= int'(fill_reg))
        else $error("mask count exceeds window fill");

    // The byte marked last leaves the window empty.
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        emit && out_last_next |=> (fill_reg == '0) && (mask_reg == '0))
        else $error("window not empty after last byte");

endmodule

### design/substring_mask_filter.sv
// Top level of the substring mask filter: channel wiring of controller and datapath.
//
// Bytes enter one per cycle, outside a flush, whenever the result register is
// free or drained in the same cycle; each byte gives at most one result once
// the window holds pattern_length bytes, so the block delays the stream by
// pattern_length - 1 bytes. After the transaction that carries end_of_stream,
// each byte still held in the window (0 to pattern_length - 1) is flushed
// singly through the result register; input is held off meanwhile.
// The pattern is compared against the whole window in parallel. A zero byte
// ends the text: it and later bytes are dropped until end_of_stream. Writing
// pattern_length starts a new stream; pattern byte writes take effect at once.
// Configuration writes are always taken and are meant to arrive while idle.
module substring_mask_filter
    import smf_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    smf_byte_if.sink     data,
    smf_result_if.source result,
    smf_cfg_if.sink      cfg
);

    smf_cmd_t    cmd;
    smf_status_t status;
    logic        in_ready;

    // Hold off input while flushing or while a result waits.
    assign data.ready = in_ready;

    smf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (data.valid),
        .in_end   (data.end_of_stream),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    smf_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_byte (data.data_byte),
        .in_end  (data.end_of_stream),
        .status  (status),
        .result  (result),
        .cfg     (cfg)
    );

endmodule

### tb/sv/smf_mask_tracker_pkg.sv
// Expected-byte tracker for the substring mask filter testbench.
package smf_mask_tracker_pkg;

    import smf_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } masked_byte_t;

    class mask_tracker;

        logic [LEN_W-1:0]      len_reg;
        logic [CFG_DATA_W-1:0] low_reg;
        logic [CFG_DATA_W-1:0] high_reg;

        logic [BYTE_W-1:0] window [PAT_BYTES];
        int unsigned       fill;
        int unsigned       mask_left;
        bit                text_ended;

        masked_byte_t pending_bytes[$];
        int unsigned  mismatches;

        function new();
            len_reg    = LEN_RESET;
            low_reg    = '0;
            high_reg   = '0;
            mismatches = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (window[i])
            begin
                window[i] = '0;
            end
            fill       = 0;
            mask_left  = 0;
            text_ended = 1'b0;
        endfunction

        // Clamp the programmed length to 1..16.
        function int unsigned active_len();
            int unsigned n;
            n = len_reg;
            if (n < 1)
            begin
                n = 1;
            end
            if (n > LEN_HW_LIMIT)
            begin
                n = LEN_HW_LIMIT;
            end
            if (n > PAT_BYTES)
            begin
                n = PAT_BYTES;
            end
            return n;
        endfunction

        function logic [BYTE_W-1:0] pattern_at(input int unsigned i);
            logic [PAT_W-1:0] both;
            both = {high_reg, low_reg};
            return both[BYTE_W*i +: BYTE_W];
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LENGTH:
                begin
                    len_reg = value[LEN_W-1:0];
                    clear_stream();
                end
                CFG_LOW:  low_reg  = value;
                CFG_HIGH: high_reg = value;
                default:  ;
            endcase
        endfunction

        function bit window_hit(input int unsigned len);
            for (int i = 0; i < len; i++)
            begin
                if (window[i] != pattern_at(i))
                begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // Consume one pending asterisk if a mask run is active.
        function logic [BYTE_W-1:0] mask_or(input logic [BYTE_W-1:0] value);
            if (mask_left > 0)
            begin
                mask_left--;
                return ASTERISK;
            end
            return value;
        endfunction

        function void queue_byte(input logic [BYTE_W-1:0] value);
            masked_byte_t item;
            item.value = value;
            item.last  = 1'b0;
            pending_bytes.push_back(item);
        endfunction

        // Note an accepted input transaction; returns 0 if the byte was ignored and carried no end_of_stream.
        function bit take_byte(input logic [BYTE_W-1:0] b, input logic eos);
            int unsigned len;
            int unsigned produced;
            bit          counted;
            len      = active_len();
            produced = 0;
            counted  = eos;
            if (!text_ended)
            begin
                counted = 1'b1;
                if (b == NUL_BYTE)
                begin
                    text_ended = 1'b1;
                end
                else
                begin
                    if (fill >= len)
                    begin
                        fill = len - 1;
                    end
                    window[fill] = b;
                    fill++;
                    if (fill == len)
                    begin
                        // a fresh match starts a run of len asterisks
                        if (mask_left == 0 && window_hit(len))
                        begin
                            mask_left = len;
                        end
                        queue_byte(mask_or(window[0]));
                        produced++;
                        for (int i = 0; i + 1 < len; i++)
                        begin
                            window[i] = window[i+1];
                        end
                        window[len-1] = '0;
                        fill--;
                    end
                end
            end
            if (eos)
            begin
                for (int i = 0; i < fill; i++)
                begin
                    queue_byte(mask_or(window[i]));
                    produced++;
                end
                if (produced > 0)
                begin
                    pending_bytes[pending_bytes.size()-1].last = 1'b1;
                end
                clear_stream();
            end
            return counted;
        endfunction

        function void check_output(input logic [BYTE_W-1:0] value, input logic last);
            masked_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                $error("out_byte 0x%02h arrived with no byte expected", value);
                return;
            end
            want = pending_bytes.pop_front();
            if (value !== want.value)
            begin
                mismatches++;
                $error("out_byte: expected 0x%02h, got 0x%02h", want.value, value);
            end
            if (last !== want.last)
            begin
                mismatches++;
                $error("out_last: expected %0b, got %0b", want.last, last);
            end
        endfunction

        function int unsigned outstanding();
            return pending_bytes.size();
        endfunction

    endclass

endpackage

### tb/sv/substring_mask_filter_tb.sv
// Self-checking testbench of the substring mask filter.
module substring_mask_filter_tb;

    import smf_pkg::*;
    import smf_mask_tracker_pkg::*;

    // Index 3 maps to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE_WAIT  = 24;   // covers the longest flush
    localparam int unsigned HOLD_CYCLES  = 300;  // long receiver back-pressure
    localparam int unsigned RANDOM_ITEMS = 200;

    logic clk;
    logic rst_n;

    smf_byte_if   data_ch ();
    smf_result_if result_ch ();
    smf_cfg_if    cfg_ch ();

    substring_mask_filter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    mask_tracker masker = new();

    bit          steady_phase = 1'b0;  // no idling on either side while set
    bit          hold_request = 1'b0;  // ask the receiver for one long hold-off
    int unsigned items_taken  = 0;
    int unsigned cycle_count  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hang: any run that gets this far has failed.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // Check every result transaction against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            masker.check_output(result_ch.out_byte, result_ch.out_last);
        end
    end

    // Receiver: random ready, plus one long hold-off on request so that the
    // block fills up and stalls its input.
    initial
    begin
        int unsigned gap;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (steady_phase)
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap != 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one byte, hold it until taken, then note it with the tracker.
    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic eos);
        int unsigned gap;
        gap = steady_phase ? 0 : pick_gap();
        if (gap != 0)
        begin
            data_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_ch.valid         <= 1'b1;
        data_ch.data_byte     <= b;
        data_ch.end_of_stream <= eos;
        do @(posedge clk); while (!data_ch.ready);
        if (masker.take_byte(b, eos))
        begin
            items_taken++;
        end
    endtask

    // Write one register; valid stays high so back-to-back writes stream.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.reg_index  <= idx;
        cfg_ch.write_data <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        masker.write_reg(idx, value);
    endtask

    task automatic configure(input logic [LEN_W-1:0] len,
                             input logic [CFG_DATA_W-1:0] low,
                             input logic [CFG_DATA_W-1:0] high);
        write_reg(CFG_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, len});
        write_reg(CFG_LOW, low);
        write_reg(CFG_HIGH, high);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected byte, then let any flush finish.
    task automatic settle();
        data_ch.valid <= 1'b0;
        while (masker.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic send_text(input string text, input bit close);
        for (int i = 0; i < text.len(); i++)
        begin
            offer_byte(text[i], close && (i == text.len() - 1));
        end
    endtask

    // Lengths: mostly short, with zero, the maximum and out-of-range values.
    function automatic logic [LEN_W-1:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return '0;
        end
        if (r < 16)
        begin
            return LEN_W'(LEN_HW_LIMIT);
        end
        if (r < 22)
        begin
            return LEN_W'($urandom_range(17, 31));
        end
        if (r < 40)
        begin
            return LEN_W'($urandom_range(7, 15));
        end
        return LEN_W'($urandom_range(1, 6));
    endfunction

    // Pattern bytes from a small alphabet so that the text often matches;
    // sometimes plant a zero inside the active length.
    function automatic logic [PAT_W-1:0] pick_pattern(input int unsigned len);
        logic [PAT_W-1:0] pat;
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                pat[BYTE_W*i +: BYTE_W] = BYTE_W'(8'h61 + $urandom_range(0, 3));
            end
            else
            begin
                pat[BYTE_W*i +: BYTE_W] = BYTE_W'($urandom_range(1, 255));
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            pat[BYTE_W*$urandom_range(0, len - 1) +: BYTE_W] = NUL_BYTE;
        end
        return pat;
    endfunction

    // Build a stream of whole patterns, broken patterns, loose pattern bytes,
    // random bytes and the odd zero, then send it.
    task automatic send_stream(input int unsigned span, input bit close);
        logic [BYTE_W-1:0] text[$];
        int unsigned       len;
        int unsigned       r;
        int unsigned       cut;
        len = masker.active_len();
        while (text.size() < span)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                for (int i = 0; i < len; i++)
                begin
                    text.push_back(masker.pattern_at(i));
                end
            end
            else if (r < 45)
            begin
                cut = $urandom_range(0, len - 1);
                for (int i = 0; i < cut; i++)
                begin
                    text.push_back(masker.pattern_at(i));
                end
                text.push_back(BYTE_W'($urandom_range(1, 255)));
            end
            else if (r < 48)
            begin
                text.push_back(NUL_BYTE);
            end
            else if (r < 70)
            begin
                text.push_back(masker.pattern_at($urandom_range(0, len - 1)));
            end
            else
            begin
                text.push_back(BYTE_W'($urandom_range(0, 255)));
            end
        end
        foreach (text[i])
        begin
            offer_byte(text[i], close && (i == text.size() - 1));
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
        int unsigned      phase;
        int unsigned      streams;
        int unsigned      span;

        // Drive every input to a known value before reset releases.
        rst_n                 = 1'b0;
        data_ch.valid         = 1'b0;
        data_ch.data_byte     = '0;
        data_ch.end_of_stream = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.reg_index      = CFG_LENGTH;
        cfg_ch.write_data     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset pattern is a single zero byte, so nothing can match. The
        // zero byte ends the text; what follows is dropped, and the flush
        // finds an empty window, so no byte carries out_last.
        write_reg(CFG_UNMAPPED, {CFG_DATA_W{1'b1}});
        cfg_ch.valid <= 1'b0;
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h01, 1'b0);
        offer_byte(NUL_BYTE, 1'b0);
        offer_byte(8'h41, 1'b0);
        offer_byte(8'h2A, 1'b1);
        settle();

        // Three-byte pattern with back-to-back matches and a flush that
        // still holds part of a candidate.
        configure(5'd3, 64'hFFFF_FFFF_FF63_6261, 64'h0);
        send_text("xabcabca", 1'b1);
        settle();

        // Leave a stream open, then rewrite the length: the held bytes are
        // dropped. A length of zero acts as one.
        send_text("ab", 1'b0);
        settle();
        configure(5'd0, 64'hFFFF_FFFF_FFFF_FF71, {CFG_DATA_W{1'b1}});
        send_text("qzq", 1'b1);
        settle();

        // Out-of-range length clamps to sixteen; the window never fills.
        configure(5'd31, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}});
        for (int i = 0; i < 5; i++)
        begin
            offer_byte(8'hFF, i == 4);
        end
        settle();

        // Random phases: new settings, random idling, one long hold-off.
        items_taken = 0;
        phase       = 0;
        while (items_taken < RANDOM_ITEMS)
        begin
            steady_phase = (phase != 1) && ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 99) < 70)
            begin
                len = pick_len();
                pat = pick_pattern((len == 0) ? 1 : (len > LEN_HW_LIMIT) ? LEN_HW_LIMIT : len);
                configure(len, pat[CFG_DATA_W-1:0], pat[PAT_W-1:CFG_DATA_W]);
            end
            else
            begin
                // Pattern bytes only: an open stream carries on.
                pat = pick_pattern(masker.active_len());
                write_reg(CFG_LOW, pat[CFG_DATA_W-1:0]);
                write_reg(CFG_HIGH, pat[PAT_W-1:CFG_DATA_W]);
                cfg_ch.valid <= 1'b0;
            end
            if (phase == 1)
            begin
                hold_request = 1'b1;
            end
            streams = $urandom_range(1, 3);
            for (int s = 0; s < streams; s++)
            begin
                span = $urandom_range(1, 3 * masker.active_len() + 4);
                if (span > 40)
                begin
                    span = 40;
                end
                send_stream(span, $urandom_range(0, 9) != 0);
            end
            settle();
            phase++;
        end

        // Close any stream left open so its held bytes come out too.
        steady_phase = 1'b0;
        offer_byte(8'h80, 1'b1);
        settle();

        if (masker.mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### substring_mask_filter.f
design/smf_pkg.sv
design/smf_byte_if.sv
design/smf_result_if.sv
design/smf_cfg_if.sv
design/smf_ctrl.sv
design/smf_datapath.sv
design/substring_mask_filter.sv
tb/sv/smf_mask_tracker_pkg.sv
tb/sv/substring_mask_filter_tb.sv
